// ----- hw/rtl/pnf_pkg.sv -----
// ----------------------------------------------------------------------------
// pnf_pkg
// Shared types, constants and coefficient lookup for the pink noise filter.
// ----------------------------------------------------------------------------
package pnf_pkg;

   localparam int SAMPLE_WIDTH_DEF = 24;
   localparam int ACCUM_WIDTH_DEF  = 32;

   // coefficients are signed with 24 fraction bits
   localparam int CF_FRAC = 24;
   localparam int CF_W    = CF_FRAC + 1;

   localparam int POLES      = 6;
   localparam int POLE_IDX_W = $clog2(POLES);

   // sequencer steps: two multiplies per pole, then the fixed tail
   localparam int NUM_STEPS = 16;
   localparam int STEP_W    = $clog2(NUM_STEPS);
   localparam logic [STEP_W-1:0] STEP_DIRECT = STEP_W'(12);
   localparam logic [STEP_W-1:0] STEP_TAP    = STEP_W'(13);
   localparam logic [STEP_W-1:0] STEP_FOLD   = STEP_W'(14);
   localparam logic [STEP_W-1:0] STEP_SCALE  = STEP_W'(15);
   localparam logic [STEP_W-1:0] STEP_FIRST_SUM = STEP_W'(3);
   localparam logic [STEP_W-1:0] STEP_FIRST_WR  = STEP_W'(2);

   typedef logic signed [CF_W-1:0]     coef_type;
   typedef logic [POLE_IDX_W-1:0]      pole_idx_type;
   typedef logic [STEP_W-1:0]          step_type;

   localparam coef_type LEAK_CF [POLES] = '{
      25'sd16758090, 25'sd16665144, 25'sd16257122,
      25'sd14537458, 25'sd9227469,  -25'sd12777528
   };
   localparam coef_type GAIN_CF [POLES] = '{
      25'sd931436,  25'sd1259565, 25'sd2581208,
      25'sd5209084, 25'sd8941454, -25'sd283501
   };
   localparam coef_type DIRECT_CF = 25'sd8995943;
   localparam coef_type TAP_CF    = 25'sd1944916;
   localparam coef_type SCALE_CF  = 25'sd3355443;

   typedef enum logic [2:0] {
      MUL_LEAK,
      MUL_GAIN,
      MUL_DIRECT,
      MUL_TAP,
      MUL_SCALE
   } mul_sel_type;

   typedef enum logic [1:0] {
      SUM_NONE,
      SUM_POLE,
      SUM_PROD,
      SUM_TAP
   } sum_sel_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic         load_sample;
      logic         mul_en;
      mul_sel_type  mul_sel;
      pole_idx_type mul_idx;
      logic         load_t;
      logic         write_pole;
      pole_idx_type wr_idx;
      sum_sel_type  sum_sel;
      logic         write_tap;
      logic         load_out;
   } cmd_type;

   function automatic coef_type pnf_coef(mul_sel_type sel, pole_idx_type idx);
      coef_type c;
      c = '0;
      case (sel)
         MUL_LEAK:   if (idx < POLE_IDX_W'(POLES)) c = LEAK_CF[idx];
         MUL_GAIN:   if (idx < POLE_IDX_W'(POLES)) c = GAIN_CF[idx];
         MUL_DIRECT: c = DIRECT_CF;
         MUL_TAP:    c = TAP_CF;
         MUL_SCALE:  c = SCALE_CF;
         default:    c = '0;
      endcase
      return c;
   endfunction

endpackage

// ----- hw/rtl/pnf_ifs.sv -----
// ----------------------------------------------------------------------------
// pnf request / response channels
// Valid-ready channels carrying one white sample in and one pink sample out.
// ----------------------------------------------------------------------------
interface pnf_req_if #(
   parameter int SAMPLE_WIDTH = pnf_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] noise_in;

   modport source (output valid, output noise_in, input ready);
   modport sink   (input valid, input noise_in, output ready);
endinterface

interface pnf_rsp_if #(
   parameter int SAMPLE_WIDTH = pnf_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] pink_out;

   modport source (output valid, output pink_out, input ready);
   modport sink   (input valid, input pink_out, output ready);
endinterface

// ----- hw/rtl/pnf_ctrl.sv -----
// ----------------------------------------------------------------------------
// pnf_ctrl
// Sequencer for the pink noise filter: steps the shared multiplier through
// the per-sample schedule and owns the handshake and result valid flag.
// ----------------------------------------------------------------------------
module pnf_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output pnf_pkg::cmd_type cmd
);
   import pnf_pkg::*;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.mul_sel = MUL_LEAK;
      cmd.sum_sel = SUM_NONE;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_sample = 1'b1;
               step_in         = '0;
               state_in        = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.mul_en = 1'b1;
            step_in    = step_ff + 1'b1;
            // pole phase: even step multiplies the leak, odd step the gain
            if (step_ff < STEP_DIRECT) begin
               cmd.mul_sel = step_ff[0] ? MUL_GAIN : MUL_LEAK;
               cmd.mul_idx = POLE_IDX_W'(step_ff >> 1);
               cmd.load_t  = step_ff[0];
            end
            if (!step_ff[0] && step_ff >= STEP_FIRST_WR && step_ff <= STEP_DIRECT) begin
               cmd.write_pole = 1'b1;
               cmd.wr_idx     = POLE_IDX_W'((step_ff >> 1) - 1'b1);
            end
            if (step_ff[0] && step_ff >= STEP_FIRST_SUM && step_ff < STEP_DIRECT) begin
               cmd.sum_sel = SUM_POLE;
            end
            if (step_ff == STEP_DIRECT) begin
               cmd.mul_sel = MUL_DIRECT;
               cmd.sum_sel = SUM_TAP;
            end
            if (step_ff == STEP_TAP) begin
               cmd.mul_sel = MUL_TAP;
               cmd.sum_sel = SUM_PROD;
            end
            if (step_ff == STEP_FOLD) begin
               cmd.mul_en    = 1'b0;
               cmd.sum_sel   = SUM_POLE;
               cmd.write_tap = 1'b1;
            end
            if (step_ff == STEP_SCALE) begin
               cmd.mul_sel = MUL_SCALE;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold the scaled product until the result register frees up
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

// ----- hw/rtl/pnf_datapath.sv -----
// ----------------------------------------------------------------------------
// pnf_datapath
// Pole accumulators, delayed tap, running sum and one shared rounding
// multiplier for the pink noise filter.
// ----------------------------------------------------------------------------
module pnf_datapath #(
   parameter int SAMPLE_WIDTH = pnf_pkg::SAMPLE_WIDTH_DEF,
   parameter int ACCUM_WIDTH  = pnf_pkg::ACCUM_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pnf_pkg::cmd_type               cmd,
   input  logic signed [SAMPLE_WIDTH-1:0] noise_in,
   output logic signed [SAMPLE_WIDTH-1:0] pink_out
);
   import pnf_pkg::*;

   // sum is clamped before scaling: beyond this range 0.2*sum saturates anyway
   localparam int CLAMP_W = SAMPLE_WIDTH + 3;
   localparam int MUL_AW  = (ACCUM_WIDTH > CLAMP_W) ? ACCUM_WIDTH : CLAMP_W;
   localparam int PW      = MUL_AW + CF_W;
   localparam int RW      = PW - CF_FRAC;
   localparam int PS_W    = RW + 1;
   localparam int SUM_W   = MUL_AW + 3;
   localparam logic signed [PW-1:0] RND = PW'(2 ** (CF_FRAC - 1));

   logic signed [SAMPLE_WIDTH-1:0] s_ff;
   logic signed [ACCUM_WIDTH-1:0]  acc_ff [POLES];
   logic signed [ACCUM_WIDTH-1:0]  tap_ff;
   logic signed [ACCUM_WIDTH-1:0]  pole_new_ff;
   logic signed [RW-1:0]           t_ff;
   logic signed [SUM_W-1:0]        sum_ff, sum_in;
   logic signed [PW-1:0]           prod_ff, prod_in;
   logic signed [SAMPLE_WIDTH-1:0] pink_ff;

   logic signed [MUL_AW-1:0]       mul_a;
   coef_type                       mul_c;
   logic signed [RW-1:0]           rnd;
   logic signed [PS_W-1:0]         pole_sum;
   logic signed [ACCUM_WIDTH-1:0]  pole_sat;
   logic signed [ACCUM_WIDTH-1:0]  tap_sat;
   logic signed [SAMPLE_WIDTH-1:0] out_sat;
   logic signed [CLAMP_W-1:0]      sum_clamp;

   // product already carries the rounding offset, so the top bits are r(x*c)
   assign rnd = prod_ff[PW-1:CF_FRAC];

   always_comb begin
      case (cmd.mul_sel)
         MUL_LEAK:  mul_a = MUL_AW'(acc_ff[cmd.mul_idx]);
         MUL_SCALE: mul_a = MUL_AW'(sum_clamp);
         default:   mul_a = MUL_AW'(s_ff);
      endcase
      mul_c   = pnf_coef(cmd.mul_sel, cmd.mul_idx);
      prod_in = mul_a * mul_c + RND;
   end

   always_comb begin
      pole_sum = PS_W'(t_ff) + PS_W'(rnd);
      if ((&pole_sum[PS_W-1:ACCUM_WIDTH-1]) || !(|pole_sum[PS_W-1:ACCUM_WIDTH-1])) begin
         pole_sat = pole_sum[ACCUM_WIDTH-1:0];
      end else begin
         pole_sat = pole_sum[PS_W-1] ? {1'b1, {(ACCUM_WIDTH-1){1'b0}}}
                                     : {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
      end

      if ((&rnd[RW-1:ACCUM_WIDTH-1]) || !(|rnd[RW-1:ACCUM_WIDTH-1])) begin
         tap_sat = rnd[ACCUM_WIDTH-1:0];
      end else begin
         tap_sat = rnd[RW-1] ? {1'b1, {(ACCUM_WIDTH-1){1'b0}}}
                             : {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
      end

      if ((&rnd[RW-1:SAMPLE_WIDTH-1]) || !(|rnd[RW-1:SAMPLE_WIDTH-1])) begin
         out_sat = rnd[SAMPLE_WIDTH-1:0];
      end else begin
         out_sat = rnd[RW-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                             : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end

      if ((&sum_ff[SUM_W-1:CLAMP_W-1]) || !(|sum_ff[SUM_W-1:CLAMP_W-1])) begin
         sum_clamp = sum_ff[CLAMP_W-1:0];
      end else begin
         sum_clamp = sum_ff[SUM_W-1] ? {1'b1, {(CLAMP_W-1){1'b0}}}
                                     : {1'b0, {(CLAMP_W-1){1'b1}}};
      end
   end

   always_comb begin
      case (cmd.sum_sel)
         SUM_POLE: sum_in = sum_ff + SUM_W'(pole_new_ff);
         SUM_PROD: sum_in = sum_ff + SUM_W'(rnd);
         SUM_TAP:  sum_in = sum_ff + SUM_W'(tap_ff);
         default:  sum_in = sum_ff;
      endcase
      if (cmd.load_sample) begin
         sum_in = '0;
      end
   end

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < POLES; k++) begin
            acc_ff[k] <= '0;
         end
         tap_ff <= '0;
      end else begin
         if (cmd.write_pole) begin
            acc_ff[cmd.wr_idx] <= pole_sat;
         end
         if (cmd.write_tap) begin
            tap_ff <= tap_sat;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         s_ff <= noise_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.load_t) begin
         t_ff <= rnd;
      end
      if (cmd.write_pole) begin
         pole_new_ff <= pole_sat;
      end
      if (cmd.load_out) begin
         pink_ff <= out_sat;
      end
      sum_ff <= sum_in;
   end

   assign pink_out = pink_ff;

endmodule

// ----- hw/rtl/pink_noise_shaping_filter.sv -----
// ----------------------------------------------------------------------------
// pink_noise_shaping_filter
// Six-pole plus tap IIR that shapes white noise into pink noise.
// ----------------------------------------------------------------------------
// Each sample is accepted in the idle state; the sequencer then steps the
// single shared rounding multiplier through its schedule (leak and gain for
// each of the six poles, then the direct term, the tap, a fold step with no
// multiply and the output scale), and the done state loads the result
// register. That multiplier schedule sets the rate. The result register is
// separate from the datapath, so a new sample is taken while the previous
// result still waits; the block only holds when a second result is ready
// before the first has been taken. All arithmetic is fixed point with
// round-to-nearest products and saturation of pole state, tap and output.
module pink_noise_shaping_filter #(
   parameter int SAMPLE_WIDTH = pnf_pkg::SAMPLE_WIDTH_DEF,
   parameter int ACCUM_WIDTH  = pnf_pkg::ACCUM_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pnf_req_if.sink    req_bus,
   pnf_rsp_if.source  rsp_bus
);
   import pnf_pkg::*;

   cmd_type cmd;

   pnf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   pnf_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .ACCUM_WIDTH  (ACCUM_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .noise_in (req_bus.noise_in),
      .pink_out (rsp_bus.pink_out)
   );

endmodule

// ----- hw/rtl/pnf_checker.sv -----
// ----------------------------------------------------------------------------
// pnf_checker
// Port-level checks for the pink noise filter, bound to the top level.
// ----------------------------------------------------------------------------
module pnf_checker #(
   parameter int SAMPLE_WIDTH = pnf_pkg::SAMPLE_WIDTH_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [SAMPLE_WIDTH-1:0] pink_out
);

   // a stalled result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pink_out))
      else $error("result beat dropped or changed while stalled");

   // leaving reset the block is empty and ready
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("block not empty after reset");

   // one sample in flight: no new beat right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second sample accepted while one is in flight");

   // a result needs the whole schedule, never appears right after an accept
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("result appeared too soon after accept");

endmodule

bind pink_noise_shaping_filter pnf_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_pnf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .pink_out  (rsp_bus.pink_out)
);

// ----- test/pnf_shaping_check.sv -----
// ----------------------------------------------------------------------------
// pnf_shaping_check
// Watches both channels of the pink noise filter, predicts each pink sample
// from the accepted white samples and compares it with the one returned.
// ----------------------------------------------------------------------------
module pnf_shaping_check (
   input  logic clock,
   input  logic reset,
   pnf_req_if   req_bus,
   pnf_rsp_if   rsp_bus,
   output int   fail_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW      = pnf_pkg::SAMPLE_WIDTH_DEF;
   localparam int AW      = pnf_pkg::ACCUM_WIDTH_DEF;
   localparam int NPOLE   = 6;
   localparam int Q_FRAC  = 24;

   typedef logic signed [SW-1:0] sample_type;

   // q24 coefficients, real value times 2^24 rounded to nearest
   localparam longint LEAK_Q24 [NPOLE] = '{
      16758090, 16665144, 16257122, 14537458, 9227469, -12777528
   };
   localparam longint GAIN_Q24 [NPOLE] = '{
      931436, 1259565, 2581208, 5209084, 8941454, -283501
   };
   localparam longint DIRECT_Q24 = 8995943;
   localparam longint TAP_Q24    = 1944916;
   localparam longint SCALE_Q24  = 3355443;

   longint     pole_state [NPOLE];
   longint     tap_state;
   sample_type pink_expected [$];

   // product rounded to nearest, ties up, formed exactly at 128 bits
   function automatic longint round_mul(input longint a, input longint c);
      logic signed [127:0] p;
      p = a;
      p = p * c;
      p = p + (128'sd1 <<< (Q_FRAC - 1));
      p = p >>> Q_FRAC;
      return p[63:0];
   endfunction

   function automatic longint clamp(input longint v, input int w);
      longint hi_lim;
      longint lo_lim;
      hi_lim = (longint'(1) <<< (w - 1)) - 1;
      lo_lim = -hi_lim - 1;
      if (v > hi_lim) return hi_lim;
      if (v < lo_lim) return lo_lim;
      return v;
   endfunction

   // advances the filter state by one white sample, returns the pink sample
   function automatic sample_type shape_sample(input sample_type s);
      longint x;
      longint acc_sum;
      int     k;
      x = longint'(s);
      acc_sum = 0;
      for (k = 0; k < NPOLE; k++) begin
         pole_state[k] = clamp(round_mul(pole_state[k], LEAK_Q24[k]) +
                               round_mul(x, GAIN_Q24[k]), AW);
         acc_sum += pole_state[k];
      end
      // tap contributes its old value before it is replaced
      acc_sum += tap_state + round_mul(x, DIRECT_Q24);
      tap_state = clamp(round_mul(x, TAP_Q24), AW);
      return sample_type'(clamp(round_mul(acc_sum, SCALE_Q24), SW));
   endfunction

   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         foreach (pole_state[i]) pole_state[i] = 0;
         tap_state = 0;
         pink_expected.delete();
         fail_count = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            pink_expected.push_back(shape_sample(req_bus.noise_in));
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pink_expected.size() == 0) begin
               $display("%0t unexpected pink_out beat: expected none actual %0d",
                        $time, rsp_bus.pink_out);
               fail_count++;
            end else begin
               want = pink_expected.pop_front();
               if (rsp_bus.pink_out !== want) begin
                  $display("%0t pink_out mismatch: expected %0d actual %0d",
                           $time, want, rsp_bus.pink_out);
                  fail_count++;
               end
            end
         end
      end
      pending_count = pink_expected.size();
   end

endmodule

// ----- test/tb_pink_noise_shaping_filter.sv -----
// ----------------------------------------------------------------------------
// tb_pink_noise_shaping_filter
// Drives white samples into the pink noise filter under random idling on
// both channels, including one long output stall, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_pink_noise_shaping_filter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW           = pnf_pkg::SAMPLE_WIDTH_DEF;
   localparam int SAMPLE_MAX   = (1 << (SW - 1)) - 1;
   localparam int SAMPLE_MIN   = -(1 << (SW - 1));
   localparam int RANDOM_ITEMS = 1080;
   localparam int PHASE_LEN    = 360;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;

   typedef logic signed [SW-1:0] sample_type;

   typedef enum int {
      PH_SRC_LIGHT,   // sender idles 37 percent, receiver 47
      PH_SRC_HEAVY,   // sender idles 47 percent, receiver 37
      PH_STEADY       // no idling after the receiver's one long hold-off
   } idle_phase_type;

   typedef enum int {
      BK_UNIFORM,
      BK_RAIL,
      BK_QUIET,
      BK_ALTERNATE,
      BK_ONE_SIGN
   } burst_kind_type;

   localparam int DIRECTED_VALS [22] = '{
      SAMPLE_MAX, SAMPLE_MIN, 0, 1, -1, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN,
      SAMPLE_MIN, 5592405, -5592406, 4194304, -4194304, 8388606, -8388607,
      SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 0, 2, -2
   };

   logic           clock = 1'b0;
   logic           reset;
   idle_phase_type phase = PH_SRC_LIGHT;
   int             fail_count;
   int             pending_count;
   int             stall_cycles;

   pnf_req_if req_bus ();
   pnf_rsp_if rsp_bus ();

   pink_noise_shaping_filter DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   pnf_shaping_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // called at a falling edge, returns at the falling edge after the beat
   task automatic offer_sample(input sample_type s);
      int gap_pct;
      gap_pct = (phase == PH_SRC_LIGHT) ? 37 : (phase == PH_SRC_HEAVY) ? 47 : 0;
      while (int'($urandom_range(99)) < gap_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.noise_in <= s;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // receiver: random ready by phase, one long hold-off when steady starts
   initial begin : rsp_drive
      bit held;
      held = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (phase == PH_STEADY && !held) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (phase == PH_SRC_LIGHT) begin
            rsp_bus.ready <= (int'($urandom_range(99)) >= 47);
         end else if (phase == PH_SRC_HEAVY) begin
            rsp_bus.ready <= (int'($urandom_range(99)) >= 37);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int             sent;
      int             burst_len;
      int             r;
      int             v;
      int             rail;
      bit             neg;
      burst_kind_type kind;
      sample_type     s;

      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.noise_in = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // rails, zero, unit steps, bit patterns and sign flips
      foreach (DIRECTED_VALS[i]) offer_sample(sample_type'(DIRECTED_VALS[i]));

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         r = $urandom_range(99);
         if (r < 35)      kind = BK_UNIFORM;
         else if (r < 60) kind = BK_RAIL;
         else if (r < 70) kind = BK_QUIET;
         else if (r < 80) kind = BK_ALTERNATE;
         else             kind = BK_ONE_SIGN;
         // long same-sign runs push the output into saturation
         burst_len = (kind == BK_RAIL || kind == BK_ONE_SIGN) ?
                     $urandom_range(150, 20) : $urandom_range(40, 5);
         neg  = $urandom_range(1);
         rail = $urandom_range(3) == 0 ? int'($urandom_range(4096)) : 0;
         for (int n = 0; n < burst_len && sent < RANDOM_ITEMS; n++) begin
            case (kind)
               BK_UNIFORM:   s = sample_type'($urandom);
               BK_RAIL:      s = neg ? sample_type'(SAMPLE_MIN + rail)
                                     : sample_type'(SAMPLE_MAX - rail);
               BK_QUIET: begin
                  v = int'($urandom_range(512)) - 256;
                  s = sample_type'(v);
               end
               BK_ALTERNATE: s = (n % 2 == 0) ? sample_type'(SAMPLE_MAX)
                                              : sample_type'(SAMPLE_MIN);
               default: begin
                  v = $urandom_range(SAMPLE_MAX);
                  s = neg ? sample_type'(-v - 1) : sample_type'(v);
               end
            endcase
            phase <= (sent < PHASE_LEN) ? PH_SRC_LIGHT :
                     (sent < 2 * PHASE_LEN) ? PH_SRC_HEAVY : PH_STEADY;
            offer_sample(s);
            sent++;
         end
      end
      req_bus.valid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
